// ===== rtl/alb_pkg.sv =====
// Shared types and constants for the antialiased line blend engine.
package alb_pkg;

   localparam int COLOR_BITS = 24;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_REPLY   = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_SINGLE  = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_PAIR    = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_HORIZ = 3'd1,
      MODE_VERT  = 3'd2,
      MODE_DIAG  = 3'd3,
      MODE_WAIT  = 3'd4
   } mode_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture input item
      logic setup;        // decode endpoints of start
      logic div_start;    // begin error step division
      logic do_advance;   // step special line
      logic do_blend;     // run blend of the reply
      logic do_walk;      // advance to next interior pair
      logic emit_first;   // load first pixel result
      logic emit_adv;     // load advance result
      logic emit_pair;    // load blended pair result
      logic emit_req;     // load background request
      logic emit_final;   // load final pixel
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       div_done;
      logic       blend_done;
      mode_type   mode;
      cmd_type    cmd;
      logic       degenerate;
      logic       special;
   } sts_type;

   function automatic logic [17:0] luma(input logic [23:0] c);
      luma = 18'(299 * c[7:0]) + 18'(587 * c[15:8]) + 18'(114 * c[23:16]);
   endfunction

endpackage

// ===== rtl/alb_if.sv =====
// Valid/ready stream interface.
interface alb_if #(parameter int WIDTH = 8) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/alb_datapath.sv =====
// Datapath: line state, error step divider, blend unit and result register.
module alb_datapath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  alb_pkg::ctl_type         ctl,
   output alb_pkg::sts_type         sts,
   input  logic [1:0]               in_cmd,
   input  logic [COORD_BITS-1:0]    in_x0,
   input  logic [COORD_BITS-1:0]    in_y0,
   input  logic [COORD_BITS-1:0]    in_x1,
   input  logic [COORD_BITS-1:0]    in_y1,
   input  logic [23:0]              in_color,
   input  logic [23:0]              in_bgm,
   input  logic [23:0]              in_bgp,
   output logic [1:0]               out_kind,
   output logic [COORD_BITS-1:0]    out_px,
   output logic [COORD_BITS-1:0]    out_py,
   output logic [23:0]              out_pc,
   output logic [COORD_BITS-1:0]    out_qx,
   output logic [COORD_BITS-1:0]    out_qy,
   output logic [23:0]              out_qc,
   output logic                     out_last
);
   localparam int CB = COORD_BITS;
   localparam int FB = FRAC_BITS;
   localparam int DB = CB + 1;           // magnitude width of a difference
   localparam int QB = CB + 1 + FB;      // dividend width
   localparam int DCW = $clog2(QB + 1);

   // captured item
   logic [1:0]  cmd_ff;
   logic [CB-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [23:0] col_in_ff, bgm_ff, bgp_ff;

   // line state
   alb_pkg::mode_type mode_ff;
   logic [CB-1:0] cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   logic          step_left_ff, y_major_ff;
   logic [15:0]   remaining_ff;
   logic [FB-1:0] acc_ff, step_ff;
   logic [23:0]   held_ff;
   logic [7:0]    weight_ff;

   // divider
   logic [QB-1:0] quo_ff;
   logic [DB:0]   rem_ff;
   logic [DB-1:0] divisor_ff;
   logic [DCW-1:0] dcnt_ff;
   logic          dbusy_ff, ddone_ff;

   // blend unit: one channel per cycle
   logic [1:0]  bch_ff;
   logic        bbusy_ff, bdone_ff;
   logic [7:0]  wm_ff, wp_ff;
   logic [23:0] bm_res_ff, bp_res_ff;

   // sorted endpoints (combinational from captured item)
   logic signed [CB-1:0] sx0, sy0, sx1, sy1;
   logic signed [CB:0]   dx_s, dy_s;
   logic [DB-1:0]        adx, ady, major, minor;
   logic                 swap;

   always_comb begin
      swap = $signed(y0_ff) > $signed(y1_ff);
      sx0  = swap ? x1_ff : x0_ff;
      sy0  = swap ? y1_ff : y0_ff;
      sx1  = swap ? x0_ff : x1_ff;
      sy1  = swap ? y0_ff : y1_ff;
      dx_s = {sx1[CB-1], sx1} - {sx0[CB-1], sx0};
      dy_s = {sy1[CB-1], sy1} - {sy0[CB-1], sy0};
      adx  = dx_s[CB] ? DB'(-dx_s) : DB'(dx_s);
      ady  = DB'(dy_s);
      major = (ady > adx) ? ady : adx;
      minor = (ady > adx) ? adx : ady;
   end

   function automatic logic [CB-1:0] xstep(input logic [CB-1:0] x, input logic left);
      xstep = left ? x - CB'(1) : x + CB'(1);
   endfunction

   // walk step
   logic [FB-1:0] acc_nx;
   logic          roll;
   logic [CB-1:0] wx, wy;
   always_comb begin
      acc_nx = acc_ff + step_ff;
      roll   = acc_nx <= acc_ff;
      if (y_major_ff) begin
         wx = roll ? xstep(cur_x_ff, step_left_ff) : cur_x_ff;
         wy = cur_y_ff + CB'(1);
      end else begin
         wy = roll ? cur_y_ff + CB'(1) : cur_y_ff;
         wx = xstep(cur_x_ff, step_left_ff);
      end
   end

   // blend channel
   logic [7:0]  cm_b, cp_b, cl;
   logic [15:0] prod_m, prod_p;
   logic [7:0]  res_m, res_p;
   always_comb begin
      unique case (bch_ff)
         2'd0:    begin cm_b = bgm_ff[7:0];   cp_b = bgp_ff[7:0];   cl = held_ff[7:0];   end
         2'd1:    begin cm_b = bgm_ff[15:8];  cp_b = bgp_ff[15:8];  cl = held_ff[15:8];  end
         default: begin cm_b = bgm_ff[23:16]; cp_b = bgp_ff[23:16]; cl = held_ff[23:16]; end
      endcase
      prod_m = wm_ff * ((cm_b > cl) ? cm_b - cl : cl - cm_b);
      prod_p = wp_ff * ((cp_b > cl) ? cp_b - cl : cl - cp_b);
      // floor(p/255) for p < 65535: (p + 1 + (p >> 8)) >> 8
      res_m = 8'((17'(prod_m) + 17'd1 + 17'(prod_m[15:8])) >> 8)
            + ((cm_b < cl) ? cm_b : cl);
      res_p = 8'((17'(prod_p) + 17'd1 + 17'(prod_p[15:8])) >> 8)
            + ((cp_b < cl) ? cp_b : cl);
   end

   logic [15:0] rem_dec;
   assign rem_dec = remaining_ff - 16'd1;

   logic [DB:0] rem_sh;
   assign rem_sh = {rem_ff[DB-1:0], quo_ff[QB-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= alb_pkg::MODE_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         step_left_ff <= 1'b0;
         y_major_ff   <= 1'b0;
         remaining_ff <= '0;
         acc_ff       <= '0;
         step_ff      <= '0;
         held_ff      <= '0;
         weight_ff    <= '0;
         dbusy_ff     <= 1'b0;
         ddone_ff     <= 1'b0;
         bbusy_ff     <= 1'b0;
         bdone_ff     <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         bdone_ff <= 1'b0;
         if (ctl.setup) begin
            held_ff      <= col_in_ff;
            cur_x_ff     <= sx0;
            cur_y_ff     <= sy0;
            end_x_ff     <= sx1;
            end_y_ff     <= sy1;
            step_left_ff <= dx_s[CB];
            acc_ff       <= '0;
            step_ff      <= '0;
            weight_ff    <= '0;
            y_major_ff   <= ady > adx;
            if (ady == '0 && adx == '0) begin
               mode_ff <= alb_pkg::MODE_IDLE;
               remaining_ff <= '0;
            end else if (ady == '0) begin
               mode_ff <= alb_pkg::MODE_HORIZ;
               remaining_ff <= 16'(adx);
            end else if (adx == '0) begin
               mode_ff <= alb_pkg::MODE_VERT;
               remaining_ff <= 16'(ady);
            end else if (adx == ady) begin
               mode_ff <= alb_pkg::MODE_DIAG;
               remaining_ff <= 16'(ady);
            end else begin
               mode_ff <= alb_pkg::MODE_WAIT;
               remaining_ff <= 16'(major) - 16'd1;
            end
         end
         if (ctl.div_start) begin
            quo_ff     <= {1'b0, minor[CB-1:0], FB'(0)};
            rem_ff     <= '0;
            divisor_ff <= major;
            dcnt_ff    <= DCW'(QB);
            dbusy_ff   <= 1'b1;
         end else if (dbusy_ff) begin
            // restoring division, one bit per cycle
            if (rem_sh >= {1'b0, divisor_ff}) begin
               rem_ff <= rem_sh - {1'b0, divisor_ff};
               quo_ff <= {quo_ff[QB-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[QB-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end
         end
         // a stale quotient never lands on the cycle a new line is set up
         if (ddone_ff && !ctl.setup) step_ff <= quo_ff[FB-1:0];
         if (ctl.do_advance) begin
            if (mode_ff != alb_pkg::MODE_VERT) cur_x_ff <= xstep(cur_x_ff, step_left_ff);
            if (mode_ff != alb_pkg::MODE_HORIZ) cur_y_ff <= cur_y_ff + CB'(1);
            remaining_ff <= rem_dec;
            if (rem_dec == '0) mode_ff <= alb_pkg::MODE_IDLE;
         end
         if (ctl.do_walk) begin
            acc_ff    <= acc_nx;
            cur_x_ff  <= wx;
            cur_y_ff  <= wy;
            weight_ff <= acc_nx[FB-1 -: 8];
         end
         if (ctl.do_blend) begin
            bch_ff   <= 2'd0;
            bbusy_ff <= 1'b1;
            wm_ff <= (alb_pkg::luma(held_ff) < alb_pkg::luma(bgm_ff)) ?
                     weight_ff : ~weight_ff;
            wp_ff <= (alb_pkg::luma(held_ff) < alb_pkg::luma(bgp_ff)) ?
                     ~weight_ff : weight_ff;
            remaining_ff <= rem_dec;
            if (rem_dec == '0) mode_ff <= alb_pkg::MODE_IDLE;
         end else if (bbusy_ff) begin
            bm_res_ff <= {res_m, bm_res_ff[23:8]};
            bp_res_ff <= {res_p, bp_res_ff[23:8]};
            bch_ff    <= bch_ff + 2'd1;
            if (bch_ff == 2'd2) begin
               bbusy_ff <= 1'b0;
               bdone_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff    <= in_cmd;
         x0_ff     <= in_x0;
         y0_ff     <= in_y0;
         x1_ff     <= in_x1;
         y1_ff     <= in_y1;
         col_in_ff <= in_color;
         bgm_ff    <= in_bgm;
         bgp_ff    <= in_bgp;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      priority if (ctl.emit_first || ctl.emit_adv || ctl.emit_final) begin
         out_kind <= alb_pkg::KIND_SINGLE;
         out_px   <= ctl.emit_final ? end_x_ff : cur_x_ff;
         out_py   <= ctl.emit_final ? end_y_ff : cur_y_ff;
         out_pc   <= held_ff;
         out_qx   <= '0;
         out_qy   <= '0;
         out_qc   <= '0;
         out_last <= ctl.emit_final || (mode_ff == alb_pkg::MODE_IDLE);
      end else if (ctl.emit_req || ctl.emit_pair) begin
         out_kind <= ctl.emit_req ? alb_pkg::KIND_REQUEST : alb_pkg::KIND_PAIR;
         out_px   <= cur_x_ff;
         out_py   <= cur_y_ff;
         out_pc   <= ctl.emit_req ? '0 : bm_res_ff;
         out_qx   <= y_major_ff ? xstep(cur_x_ff, step_left_ff) : cur_x_ff;
         out_qy   <= y_major_ff ? cur_y_ff : cur_y_ff + CB'(1);
         out_qc   <= ctl.emit_req ? '0 : bp_res_ff;
         out_last <= 1'b0;
      end else begin
      end
   end

   always_comb begin
      sts.div_done   = ddone_ff;
      sts.blend_done = bdone_ff;
      sts.mode       = mode_ff;
      sts.cmd        = alb_pkg::cmd_type'(cmd_ff);
      sts.degenerate = (mode_ff == alb_pkg::MODE_IDLE);
      sts.special    = (mode_ff == alb_pkg::MODE_HORIZ) || (mode_ff == alb_pkg::MODE_VERT)
                    || (mode_ff == alb_pkg::MODE_DIAG);
   end

   assert property (@(posedge clock) disable iff (reset) ddone_ff |-> !dbusy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) bdone_ff |-> !bbusy_ff)
      else $error("blend done while busy");
   assert property (@(posedge clock) disable iff (reset)
      ctl.do_walk |-> mode_ff == alb_pkg::MODE_WAIT)
      else $error("walk outside sloped line");
endmodule

// ===== rtl/alb_ctrl.sv =====
// Controller state machine sequencing the datapath and the result handshake.
module alb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  alb_pkg::sts_type sts,
   output alb_pkg::ctl_type ctl
);
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_FIRST  = 10'b0000000100,
      S_DIV    = 10'b0000001000,
      S_WALK   = 10'b0000010000,
      S_REQ    = 10'b0000100000,
      S_BLEND  = 10'b0001000000,
      S_PAIR   = 10'b0010000000,
      S_NEXT   = 10'b0100000000,
      S_SEND   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in, after_ff, after_in;
   logic      send_ff, send_in;   // result register holds an item not yet taken

   logic rsp_fire;
   assign rsp_fire = send_ff && rsp_ready;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      send_in  = send_ff && !rsp_ready;
      ctl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !send_ff || rsp_ready;
            if (req_valid && req_ready) begin
               ctl.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.cmd)
               alb_pkg::CMD_START: begin
                  ctl.setup = 1'b1;
                  ctl.div_start = 1'b1;
                  state_in = S_FIRST;
               end
               alb_pkg::CMD_ADVANCE: begin
                  if (sts.special) begin
                     ctl.do_advance = 1'b1;
                     after_in = S_IDLE;
                     state_in = S_SEND;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               alb_pkg::CMD_REPLY: begin
                  if (sts.mode == alb_pkg::MODE_WAIT) begin
                     ctl.do_blend = 1'b1;
                     state_in = S_BLEND;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FIRST: begin
            ctl.emit_first = 1'b1;
            send_in = 1'b1;
            state_in = (sts.mode == alb_pkg::MODE_WAIT) ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_WALK;
         end
         S_WALK: begin
            // step_ff is written on the done cycle, valid here
            ctl.do_walk = 1'b1;
            after_in = S_IDLE;
            state_in = S_REQ;
         end
         S_REQ: begin
            if (!send_ff || rsp_ready) begin
               ctl.emit_req = 1'b1;
               send_in = 1'b1;
               state_in = after_ff;
            end
         end
         S_BLEND: begin
            if (sts.blend_done) state_in = S_PAIR;
         end
         S_PAIR: begin
            if (!send_ff || rsp_ready) begin
               ctl.emit_pair = 1'b1;
               send_in = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (sts.degenerate) begin
               after_in = S_IDLE;
               state_in = S_SEND;
            end else begin
               ctl.do_walk = 1'b1;
               after_in = S_IDLE;
               state_in = S_REQ;
            end
         end
         S_SEND: begin
            if (!send_ff || rsp_ready) begin
               if (after_ff == S_IDLE && sts.degenerate && sts.cmd == alb_pkg::CMD_REPLY)
                  ctl.emit_final = 1'b1;
               else
                  ctl.emit_adv = 1'b1;
               send_in = 1'b1;
               state_in = after_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= S_IDLE;
         send_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         send_ff  <= send_in;
      end
   end

   assign rsp_valid = send_ff;

   assert property (@(posedge clock) disable iff (reset) req_ready |-> state_ff == S_IDLE)
      else $error("input taken while busy");
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      (send_ff && !rsp_fire) |=> send_ff)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (ctl.emit_pair || ctl.emit_req) |-> (!send_ff || rsp_ready))
      else $error("result overwritten");
endmodule

// ===== rtl/antialiased_line_blend_engine_top.sv =====
// Top level of the antialiased line blend engine.
//  channel | direction | payload
//  req     | in        | cmd, endpoints, line color, two background colors
//  rsp     | out       | kind, main pixel, partner pixel, last
// A start emits the first pixel; a sloped start then runs the serial error-step
// divider over COORD_BITS+FRAC_BITS+1 quotient bits, then walks and requests.
// An advance steps a special line; a reply blends (blend is one channel a cycle).
// Reset is synchronous and clears the controller and datapath line and busy state.
// One item is worked at a time; a held result stalls the next result and new input.
module antialiased_line_blend_engine_top #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input logic clock,
   input logic reset,
   alb_if.sink   req,
   alb_if.source rsp
);
   localparam int CB = COORD_BITS;

   alb_pkg::ctl_type ctl;
   alb_pkg::sts_type sts;

   alb_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .sts, .ctl
   );

   alb_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .ctl, .sts,
      .in_cmd   (req.data[1:0]),
      .in_x0    (req.data[2 +: CB]),
      .in_y0    (req.data[2+CB +: CB]),
      .in_x1    (req.data[2+2*CB +: CB]),
      .in_y1    (req.data[2+3*CB +: CB]),
      .in_color (req.data[2+4*CB +: 24]),
      .in_bgm   (req.data[26+4*CB +: 24]),
      .in_bgp   (req.data[50+4*CB +: 24]),
      .out_kind (rsp.data[1:0]),
      .out_px   (rsp.data[2 +: CB]),
      .out_py   (rsp.data[2+CB +: CB]),
      .out_pc   (rsp.data[2+2*CB +: 24]),
      .out_qx   (rsp.data[26+2*CB +: CB]),
      .out_qy   (rsp.data[26+3*CB +: CB]),
      .out_qc   (rsp.data[26+4*CB +: 24]),
      .out_last (rsp.data[50+4*CB])
   );
endmodule
